// ----- rtl/ecpg_pkg.sv -----
// shared types and constants for the ega character cell pixel generator
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package ecpg_pkg;

   // render modes
   localparam logic [1:0] MODE_COLOR_TEXT = 2'd0;
   localparam logic [1:0] MODE_MONO_TEXT  = 2'd1;
   localparam logic [1:0] MODE_PLANAR     = 2'd2;
   localparam logic [1:0] MODE_CGA        = 2'd3;

   // column classes
   localparam logic [1:0] COL_INTERIOR = 2'd0;
   localparam logic [1:0] COL_FIRST    = 2'd1;
   localparam logic [1:0] COL_LAST     = 2'd2;
   localparam logic [1:0] COL_BEYOND   = 2'd3;

   // register indexes
   localparam logic [2:0] REG_RENDER_MODE      = 3'd0;
   localparam logic [2:0] REG_BLINK_ENABLE     = 3'd1;
   localparam logic [2:0] REG_PEL_PAN          = 3'd2;
   localparam logic [2:0] REG_PLANE_ENABLE     = 3'd3;
   localparam logic [2:0] REG_CURSOR_START_ROW = 3'd4;
   localparam logic [2:0] REG_CURSOR_END_ROW   = 3'd5;
   localparam logic [2:0] REG_UNDERLINE_ROW    = 3'd6;
   localparam logic [2:0] REG_CELL_WIDTH       = 3'd7;

   localparam int CSR_DATA_W = 5;
   localparam int MAX_DOTS   = 9;
   localparam int POS_W      = 4;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] ATTR_REV_MASK  = 8'b0111_0111;
   localparam logic [7:0] ATTR_REV_VALUE = 8'b0111_0000;
   localparam logic [7:0] LINE_CHAR_LOW  = 8'hC0;
   localparam logic [7:0] LINE_CHAR_HIGH = 8'hDF;
   localparam logic [3:0] WHITE_INDEX    = 4'h F;
   localparam logic [3:0] BLINK_FLIP     = 4'b1000;
   localparam logic [3:0] FG_LOW_BITS    = 4'b0111;

   typedef struct packed {
      logic [1:0] render_mode;
      logic       blink_enable;
      logic [2:0] pel_pan;
      logic [3:0] plane_enable;
      logic [4:0] cursor_start_row;
      logic [4:0] cursor_end_row;
      logic [4:0] underline_row;
      logic [3:0] cell_width;
   } cfg_type;

   // one character clock worth of dots, in emit order, with the span to send
   typedef struct packed {
      logic [MAX_DOTS-1:0][3:0] colors;
      logic [POS_W-1:0]         first;
      logic [POS_W-1:0]         last;
      logic                     border;
   } job_type;

endpackage

// ----- rtl/ecpg_front.sv -----
// front end: decodes one character clock into a row of colour indices
// depends on ecpg_pkg
`timescale 1ns / 1ps

module ecpg_front (
   input  ecpg_pkg::cfg_type cfg,
   input  logic              in_display,
   input  logic [1:0]        column_class,
   input  logic [7:0]        plane0,
   input  logic [7:0]        plane1,
   input  logic [7:0]        plane2,
   input  logic [7:0]        plane3,
   input  logic [7:0]        font_row,
   input  logic [4:0]        cell_row,
   input  logic              cursor_here,
   input  logic              blink_phase,
   output ecpg_pkg::job_type job,
   output logic              job_has_dots
);
   import ecpg_pkg::*;

   logic             cursor_line;
   logic             mono_nine;
   logic [POS_W-1:0] mono_last;
   logic [3:0][7:0]  pm;
   logic [POS_W-1:0] pan_ext;

   assign mono_nine = (cfg.cell_width >= 4'd9);
   assign mono_last = mono_nine ? POS_W'(8) : POS_W'(7);
   assign pan_ext   = POS_W'(cfg.pel_pan);

   always_comb begin
      cursor_line = cursor_here && (cell_row > cfg.cursor_start_row);
      if ((cfg.cursor_end_row != 5'd0) && (cell_row > cfg.cursor_end_row)) begin
         cursor_line = 1'b0;
      end
   end

   // disabled planes read zero in the graphics modes
   always_comb begin
      pm[0] = cfg.plane_enable[0] ? plane0 : 8'd0;
      pm[1] = cfg.plane_enable[1] ? plane1 : 8'd0;
      pm[2] = cfg.plane_enable[2] ? plane2 : 8'd0;
      pm[3] = cfg.plane_enable[3] ? plane3 : 8'd0;
   end

   always_comb begin
      logic [3:0] bg;
      logic [3:0] fg;
      logic       cblink;
      logic       draw;
      logic       rev;
      logic       uline;
      logic       under;
      logic       dot;
      logic       line_char;
      logic       pan_span;
      logic [1:0] cga_j;
      logic       cga_h;

      job          = '0;
      job_has_dots = 1'b1;
      bg           = 4'd0;
      fg           = 4'd0;
      cblink       = 1'b0;
      draw         = 1'b1;
      rev          = 1'b0;
      uline        = 1'b0;
      under        = 1'b0;
      dot          = 1'b0;
      line_char    = 1'b0;
      pan_span     = 1'b0;
      cga_j        = 2'd0;
      cga_h        = 1'b0;

      // dot span for panned modes
      job.first = POS_W'(0);
      job.last  = POS_W'(7);
      if (column_class == COL_FIRST) begin
         job.first = pan_ext;
      end else if (column_class == COL_LAST) begin
         job.last     = pan_ext - POS_W'(1);
         job_has_dots = (cfg.pel_pan != 3'd0);
      end

      case (cfg.render_mode)
         MODE_COLOR_TEXT: begin
            pan_span = 1'b1;
            bg = plane1[7:4];
            fg = plane1[3:0];
            if (cfg.blink_enable) begin
               cblink = plane1[7];
               bg     = {1'b0, plane1[6:4]};
            end
            draw = !cblink || blink_phase;
            for (int k = 0; k < 8; k++) begin
               job.colors[k] = ((draw && font_row[7-k]) || cursor_line) ? fg : bg;
            end
         end
         MODE_MONO_TEXT: begin
            cblink    = cfg.blink_enable && plane1[7];
            uline     = (plane1[2:0] == 3'd1);
            rev       = ((plane1 & ATTR_REV_MASK) == ATTR_REV_VALUE);
            fg        = ((plane1 & ATTR_REV_MASK) != 8'd0) ?
                        ({plane1[3], 3'b000} | FG_LOW_BITS) : 4'd0;
            if (rev) begin
               fg = fg ^ FG_LOW_BITS;
            end
            bg        = (rev || (!cfg.blink_enable && plane1[7])) ? WHITE_INDEX : 4'd0;
            draw      = !cblink || blink_phase;
            under     = draw && uline && (cell_row == cfg.underline_row);
            line_char = (plane0 >= LINE_CHAR_LOW) && (plane0 <= LINE_CHAR_HIGH);
            for (int k = 0; k < 8; k++) begin
               dot = draw && font_row[7-k];
               job.colors[k] = (dot || cursor_line || under) ? fg : bg;
            end
            // ninth dot repeats the eighth for line drawing codes
            dot = line_char && draw && font_row[0];
            job.colors[8] = (dot || cursor_line || under) ? fg : bg;
            job.first     = POS_W'(0);
            job.last      = mono_last;
            job_has_dots  = 1'b1;
            if (!in_display || (column_class == COL_LAST)) begin
               job.colors = '0;
               job.border = 1'b1;
            end
         end
         MODE_PLANAR: begin
            pan_span = 1'b1;
            for (int k = 0; k < 8; k++) begin
               job.colors[k] = {pm[3][7-k], pm[2][7-k], pm[1][7-k], pm[0][7-k]};
               if (cfg.blink_enable && blink_phase) begin
                  job.colors[k] = job.colors[k] ^ BLINK_FLIP;
               end
            end
         end
         default: begin
            // packed 2-bit pixels: planes 0/2 feed the left half, 1/3 the right
            for (int k = 0; k < 8; k++) begin
               cga_h = (k >= 4);
               cga_j = 2'(3 - (k % 4));
               job.colors[k] = {pm[{1'b1, cga_h}][{cga_j, 1'b1}],
                                pm[{1'b1, cga_h}][{cga_j, 1'b0}],
                                pm[{1'b0, cga_h}][{cga_j, 1'b1}],
                                pm[{1'b0, cga_h}][{cga_j, 1'b0}]};
            end
            job.first    = POS_W'(0);
            job.last     = POS_W'(7);
            job_has_dots = 1'b1;
            if (!in_display || (column_class == COL_LAST) ||
                (column_class == COL_BEYOND)) begin
               job.colors = '0;
               job.border = 1'b1;
            end
         end
      endcase

      // border for the panned modes outside the display
      if (pan_span && !in_display) begin
         job.colors   = '0;
         job.border   = 1'b1;
         job.first    = POS_W'(0);
         job.last     = POS_W'(7);
         job_has_dots = 1'b1;
      end
   end

endmodule

// ----- rtl/ecpg_queue.sv -----
// two-entry job queue between the decode front end and the serializer
// depends on ecpg_pkg
`timescale 1ns / 1ps

module ecpg_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ecpg_pkg::job_type push_job,
   input  logic              pop,
   output ecpg_pkg::job_type head_job,
   output logic              not_empty,
   output logic              full
);
   import ecpg_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   job_type                  entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [$clog2(QUEUE_DEPTH+1)-1:0] count_ff, count_in;

   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH));
   assign head_job  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ----- rtl/ecpg_back.sv -----
// back end: one dot per unstalled cycle from queue head to output register
// depends on ecpg_pkg
`timescale 1ns / 1ps

module ecpg_back (
   input  logic              clock,
   input  logic              reset,
   input  ecpg_pkg::job_type head_job,
   input  logic              head_valid,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [3:0]        rsp_color_index,
   output logic              rsp_is_border,
   output logic              rsp_last_pixel
);
   import ecpg_pkg::*;

   logic             started_ff, started_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             valid_ff, valid_in;
   logic [3:0]       color_ff, color_in;
   logic             border_ff, border_in;
   logic             last_ff, last_in;
   logic             advance;
   logic [POS_W-1:0] cur_pos;
   logic             at_last;

   assign advance = !valid_ff || !rsp_stall;
   assign cur_pos = started_ff ? pos_ff : head_job.first;
   assign at_last = (cur_pos == head_job.last);
   assign pop     = advance && head_valid && at_last;

   always_comb begin
      started_in = started_ff;
      pos_in     = pos_ff;
      valid_in   = valid_ff;
      color_in   = color_ff;
      border_in  = border_ff;
      last_in    = last_ff;
      if (advance) begin
         valid_in = head_valid;
         if (head_valid) begin
            color_in   = head_job.colors[cur_pos];
            border_in  = head_job.border;
            last_in    = at_last;
            started_in = !at_last;
            pos_in     = cur_pos + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
         valid_ff   <= 1'b0;
      end else begin
         started_ff <= started_in;
         valid_ff   <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff    <= pos_in;
      color_ff  <= color_in;
      border_ff <= border_in;
      last_ff   <= last_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_color_index = color_ff;
   assign rsp_is_border   = border_ff;
   assign rsp_last_pixel  = last_ff;

endmodule

// ----- rtl/ega_char_cell_pixel_generator.sv -----
// top level of the ega character cell pixel generator: registers, front, queue, back
// depends on ecpg_pkg, ecpg_front, ecpg_queue, ecpg_back
`timescale 1ns / 1ps

// usage
// - req_ channel: one transaction per character clock (plane bytes, font row,
//   cell row, column class, cursor and blink flags); taken when req_valid is
//   high and req_stall low
// - rsp_ channel: one transaction per pixel, 0 to 9 per character clock, the
//   final one flagged by rsp_last_pixel; a character clock that yields no pixel
//   (last column with no panning) produces no transaction at all
// - csr_ port: write-only, csr_addr picks the register, csr_wdata low bits
//   carry the value; write only while the block is idle
// - path: a taken request is decoded into the queue at the accepting edge,
//   then the serializer moves its pixels into the output register
// - throughput: one pixel per cycle from the serializer while rsp_stall is
//   low; a character clock has 8 or 9 pixels typically
// - a two-entry queue sits between decode and serializer, so requests keep
//   being taken while pixels of earlier ones are still going out
// - stall on rsp_ freezes the output register; the queue fills and then
//   req_stall rises
// - reset: queue empty, no pixel pending, registers at their defaults
//   (colour text, plane enable all set, underline row 31, 8-dot cells)

module ega_char_cell_pixel_generator (
   input  logic        clock,
   input  logic        reset,
   // request transactions
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_in_display,
   input  logic [1:0]  req_column_class,
   input  logic [7:0]  req_plane0,
   input  logic [7:0]  req_plane1,
   input  logic [7:0]  req_plane2,
   input  logic [7:0]  req_plane3,
   input  logic [7:0]  req_font_row,
   input  logic [4:0]  req_cell_row,
   input  logic        req_cursor_here,
   input  logic        req_blink_phase,
   // pixel transactions
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_color_index,
   output logic        rsp_is_border,
   output logic        rsp_last_pixel,
   // register writes
   input  logic        csr_wen,
   input  logic [2:0]  csr_addr,
   input  logic [ecpg_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import ecpg_pkg::*;

   cfg_type cfg_ff, cfg_in;
   job_type front_job;
   job_type head_job;
   logic    front_has_dots;
   logic    queue_full;
   logic    queue_not_empty;
   logic    queue_push;
   logic    queue_pop;

   // register file; the user must write it only between transactions, the block does not enforce this
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         case (csr_addr)
            REG_RENDER_MODE:      cfg_in.render_mode      = csr_wdata[1:0];
            REG_BLINK_ENABLE:     cfg_in.blink_enable     = csr_wdata[0];
            REG_PEL_PAN:          cfg_in.pel_pan          = csr_wdata[2:0];
            REG_PLANE_ENABLE:     cfg_in.plane_enable     = csr_wdata[3:0];
            REG_CURSOR_START_ROW: cfg_in.cursor_start_row = csr_wdata[4:0];
            REG_CURSOR_END_ROW:   cfg_in.cursor_end_row   = csr_wdata[4:0];
            REG_UNDERLINE_ROW:    cfg_in.underline_row    = csr_wdata[4:0];
            REG_CELL_WIDTH:       cfg_in.cell_width       = csr_wdata[3:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.render_mode      <= MODE_COLOR_TEXT;
         cfg_ff.blink_enable     <= 1'b0;
         cfg_ff.pel_pan          <= 3'd0;
         cfg_ff.plane_enable     <= 4'hF;
         cfg_ff.cursor_start_row <= 5'd0;
         cfg_ff.cursor_end_row   <= 5'd0;
         cfg_ff.underline_row    <= 5'd31;
         cfg_ff.cell_width       <= 4'd8;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // decode of the character clock into a row of colour indices
   ecpg_front u_front (
      .cfg          (cfg_ff),
      .in_display   (req_in_display),
      .column_class (req_column_class),
      .plane0       (req_plane0),
      .plane1       (req_plane1),
      .plane2       (req_plane2),
      .plane3       (req_plane3),
      .font_row     (req_font_row),
      .cell_row     (req_cell_row),
      .cursor_here  (req_cursor_here),
      .blink_phase  (req_blink_phase),
      .job          (front_job),
      .job_has_dots (front_has_dots)
   );

   // requests wait only for queue space; empty rows are dropped here
   assign req_stall  = queue_full;
   assign queue_push = req_valid && !queue_full && front_has_dots;

   ecpg_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (queue_push),
      .push_job  (front_job),
      .pop       (queue_pop),
      .head_job  (head_job),
      .not_empty (queue_not_empty),
      .full      (queue_full)
   );

   // serializer with output register
   ecpg_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_job        (head_job),
      .head_valid      (queue_not_empty),
      .pop             (queue_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_color_index (rsp_color_index),
      .rsp_is_border   (rsp_is_border),
      .rsp_last_pixel  (rsp_last_pixel)
   );

endmodule
